/* rtl/mccp_pkg.sv */
`timescale 1ns / 1ps

package mccp_pkg;

    // Attenuation applied ahead of every output format
    localparam int unsigned ATTEN_SHIFT = 4;

    localparam int unsigned SHIFT_U8  = 24 - ATTEN_SHIFT;
    localparam int unsigned SHIFT_S16 = 16 - ATTEN_SHIFT;
    localparam int unsigned SHIFT_S24 = 8 - ATTEN_SHIFT;
    localparam int unsigned SHIFT_S32 = ATTEN_SHIFT;

    // Offset that turns the signed 8-bit code into unsigned PCM
    localparam logic [7:0] U8_BIAS = 8'h80;

    localparam logic signed [31:0] CLIP_LOW_RST  = -32'sd134217728;
    localparam logic [30:0]        CLIP_HIGH_RST = 31'd134217727;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } fmt_t;

    localparam fmt_t FMT_RST = FMT_S16;

    typedef enum logic [1:0] {
        CFG_CLIP_LOW   = 2'd0,
        CFG_CLIP_HIGH  = 2'd1,
        CFG_OUT_FORMAT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] sample_even;
        logic signed [31:0] sample_odd;
        logic               first_frame;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] word_even;
        logic signed [31:0] word_odd;
        logic signed [31:0] min_even;
        logic signed [31:0] max_even;
        logic signed [31:0] min_odd;
        logic signed [31:0] max_odd;
    } out_beat_t;

    // Configuration seen by every lane
    typedef struct packed {
        logic signed [31:0] clip_low;
        logic [30:0]        clip_high;
        fmt_t               out_format;
    } lane_cfg_t;

    // Pipeline control shared by the lanes
    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic first_frame;
    } lane_ctrl_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic signed [31:0] word;
        logic signed [31:0] peak_min;
        logic signed [31:0] peak_max;
    } lane_res_t;

    // Arithmetic shift into the selected format, wrapping to its width
    function automatic logic signed [31:0] convert_sample(
        input logic signed [31:0] n,
        input fmt_t               fmt
    );
        logic signed [31:0] s8;
        logic signed [31:0] s16;
        logic signed [31:0] s24;
        logic signed [31:0] s32;
        logic signed [31:0] r;
        s8  = n >>> SHIFT_U8;
        s16 = n >>> SHIFT_S16;
        s24 = n >>> SHIFT_S24;
        s32 = n >>> SHIFT_S32;
        unique case (fmt)
            FMT_U8:  r = {24'd0, s8[7:0] ^ U8_BIAS};
            FMT_S16: r = {{16{s16[15]}}, s16[15:0]};
            FMT_S24: r = {{8{s24[23]}}, s24[23:0]};
            FMT_S32: r = s32;
        endcase
        return r;
    endfunction

endpackage

/* rtl/mccp_lane.sv */
`timescale 1ns / 1ps

module mccp_lane
    import mccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_cfg_t          cfg,
    input  lane_ctrl_t         ctrl,
    input  logic signed [31:0] sample,
    output lane_res_t          res
);

    logic signed [31:0] clip_hi_s;
    logic signed [31:0] clamp_next;
    logic signed [31:0] clamp_reg;
    logic signed [31:0] peak_min_reg;
    logic signed [31:0] peak_max_reg;
    logic signed [31:0] base_min;
    logic signed [31:0] base_max;
    logic signed [31:0] peak_min_next;
    logic signed [31:0] peak_max_next;

    assign clip_hi_s = {1'b0, cfg.clip_high};

    // Stage 1: clamp; if inverted, below low gives low, else high
    always_comb
    begin
        priority if (sample < cfg.clip_low)
            clamp_next = cfg.clip_low;
        else if (sample > clip_hi_s)
            clamp_next = clip_hi_s;
        else
            clamp_next = sample;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
            clamp_reg <= clamp_next;
    end

    // Stage 2: peak meter, a new minimum skips the maximum check
    always_comb
    begin
        base_min      = ctrl.first_frame ? clip_hi_s : peak_min_reg;
        base_max      = ctrl.first_frame ? cfg.clip_low : peak_max_reg;
        peak_min_next = base_min;
        peak_max_next = base_max;
        priority if (clamp_reg < base_min)
            peak_min_next = clamp_reg;
        else if (clamp_reg > base_max)
            peak_max_next = clamp_reg;
        else
            peak_max_next = base_max;   // within range: both meters hold
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_min_reg <= {1'b0, CLIP_HIGH_RST};
            peak_max_reg <= CLIP_LOW_RST;
        end
        else if (ctrl.load_s2)
        begin
            peak_min_reg <= peak_min_next;
            peak_max_reg <= peak_max_next;
        end
    end

    assign res.word     = convert_sample(clamp_reg, cfg.out_format);
    assign res.peak_min = peak_min_next;
    assign res.peak_max = peak_max_next;

endmodule

/* rtl/mccp_merge.sv */
`timescale 1ns / 1ps

module mccp_merge
    import mccp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  lane_res_t res_even,
    input  lane_res_t res_odd,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_beat_t data_reg;
    out_beat_t data_next;

    // Output register frees up when empty or when its beat leaves
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        data_next.word_even = res_even.word;
        data_next.word_odd  = res_odd.word;
        data_next.min_even  = res_even.peak_min;
        data_next.max_even  = res_even.peak_max;
        data_next.min_odd   = res_odd.peak_min;
        data_next.max_odd   = res_odd.peak_max;
        valid_next          = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/mix_clip_convert_peak_unit.sv */
`timescale 1ns / 1ps

// Stereo mix-frame clip, peak meter and PCM format converter.
// Input channel (in_valid/in_ready/in_data): one stereo frame per beat, two
// 32-bit mix samples plus a first-frame flag that reloads the peak meters
// from the clip bounds before the frame is metered.
// Output channel (out_valid/out_ready/out_data): one beat per frame with both
// converted words and the running min/max of each slot after that frame.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 clip low,
// 1 clip high, 2 output format; index 3 is ignored. Always ready; write only
// while no frame is in flight.
// Path: an input beat is registered in the clamp stage, then the
// peak/convert stage feeds the output register.
// Throughput: 1 frame per cycle while the receiver accepts; both slots run
// in parallel lanes and the per-slot peak feedback closes within stage two.
// Reset: config returns to its defaults, peak meters to the default clip
// bounds, pipeline empties.
// Receiver stall: the output register holds its beat; the stage behind it
// holds as well, and in_ready drops only once both stages are full.
module mix_clip_convert_peak_unit
    import mccp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  logic [31:0] cfg_data
);

    lane_cfg_t  cfg_reg;
    lane_ctrl_t ctrl;
    lane_res_t  res_even;
    lane_res_t  res_odd;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_first_reg;
    logic       can_load;
    logic       load_s2;
    logic       load_s1;

    assign cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_low   <= CLIP_LOW_RST;
            cfg_reg.clip_high  <= CLIP_HIGH_RST;
            cfg_reg.out_format <= FMT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CLIP_LOW:   cfg_reg.clip_low   <= cfg_data;
                CFG_CLIP_HIGH:  cfg_reg.clip_high  <= cfg_data[30:0];
                CFG_OUT_FORMAT: cfg_reg.out_format <= fmt_t'(cfg_data[1:0]);
                CFG_UNUSED:     ;
            endcase
        end
    end

    // Pipeline flow control
    assign load_s2       = s1_valid_reg && can_load;
    assign in_ready      = !s1_valid_reg || can_load;
    assign load_s1       = in_valid && in_ready;
    assign s1_valid_next = load_s1 ? 1'b1 : (load_s2 ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
            s1_first_reg <= in_data.first_frame;
    end

    assign ctrl.load_s1     = load_s1;
    assign ctrl.load_s2     = load_s2;
    assign ctrl.first_frame = s1_first_reg;

    // Slot lanes
    mccp_lane u_lane_even (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctrl   (ctrl),
        .sample (in_data.sample_even),
        .res    (res_even)
    );

    mccp_lane u_lane_odd (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctrl   (ctrl),
        .sample (in_data.sample_odd),
        .res    (res_odd)
    );

    // Merge lanes into the output beat
    mccp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load_s2),
        .res_even  (res_even),
        .res_odd   (res_odd),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
